// ===== hdl/audio_compressor_attack_hold_release_unit_defines.svh =====
// Assertion macros shared by the compressor RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef AUDIO_COMPRESSOR_ATTACK_HOLD_RELEASE_UNIT_DEFINES_SVH
`define AUDIO_COMPRESSOR_ATTACK_HOLD_RELEASE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define ACHR_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define ACHR_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/achr_pkg.sv =====
// Types and constants for the attack/hold/release compressor.
// No dependencies; used by every module of the block.
`default_nettype none

package achr_pkg;

  localparam int SAMPLE_W       = 32;
  localparam int GAIN_FRAC_BITS = 24;
  localparam int GAIN_W         = GAIN_FRAC_BITS + 2;
  localparam int STEP_W         = 25;
  localparam int LEN_W          = 20;
  localparam int CFG_INDEX_W    = 3;
  localparam int CFG_DATA_W     = 32;

  typedef logic [GAIN_W-1:0] gain_t;

  localparam gain_t GAIN_ONE = {2'b01, {GAIN_FRAC_BITS{1'b0}}};
  localparam gain_t GAIN_MAX = {GAIN_W{1'b1}};

  localparam logic [SAMPLE_W-1:0] SAT_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAT_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_ATTACK  = 2'd1,
    MODE_HOLD    = 2'd2,
    MODE_RELEASE = 2'd3
  } mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LEVEL_THRESHOLD   = 3'd0,
    REG_GAIN_FLOOR        = 3'd1,
    REG_ATTACK_GAIN_STEP  = 3'd2,
    REG_RELEASE_GAIN_STEP = 3'd3,
    REG_ATTACK_LENGTH     = 3'd4,
    REG_RELEASE_LENGTH    = 3'd5,
    REG_HOLD_LENGTH       = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] level_threshold;
    logic [STEP_W-1:0]   gain_floor;
    logic [STEP_W-1:0]   attack_gain_step;
    logic [STEP_W-1:0]   release_gain_step;
    logic [LEN_W-1:0]    attack_length;
    logic [LEN_W-1:0]    release_length;
    logic [LEN_W-1:0]    hold_length;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    level_threshold:   32'd214748365,
    gain_floor:        25'd8388608,
    attack_gain_step:  25'd2796,
    release_gain_step: 25'd4194,
    attack_length:     20'd3000,
    release_length:    20'd2000,
    hold_length:       20'd1000
  };

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] compressed_sample;
    logic signed [SAMPLE_W-1:0] mono_passthrough;
    logic [GAIN_W-1:0]          current_gain;
    logic [1:0]                 current_mode;
  } out_item_t;

  // mono mix stage result
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mono;
    logic [SAMPLE_W-1:0]        mag;
    logic                       neg;
  } mix_t;

  // everything the gain multiplier needs
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mono;
    logic [SAMPLE_W-1:0]        mag;
    logic                       neg;
    gain_t                      gain;
    mode_t                      mode;
  } apply_in_t;

endpackage

`default_nettype wire

// ===== hdl/achr_mix.sv =====
// Stereo-to-mono mix and magnitude, one register stage.
// Depends on achr_pkg.
`default_nettype none

module achr_mix (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire achr_pkg::in_item_t item,
  output achr_pkg::mix_t         mix
);

  logic signed [achr_pkg::SAMPLE_W-1:0] mono_c;
  logic [achr_pkg::SAMPLE_W-1:0]        mag_c;

  // halves cannot overflow when summed
  assign mono_c = (item.left_sample >>> 1) + (item.right_sample >>> 1);
  // most negative mono maps to 2^31 unsigned, which is exact
  assign mag_c  = mono_c[achr_pkg::SAMPLE_W-1] ? (achr_pkg::SAMPLE_W'(0) - $unsigned(mono_c))
                                               : $unsigned(mono_c);

  always_ff @(posedge clk) begin
    if (en) begin
      mix.mono <= mono_c;
      mix.mag  <= mag_c;
      mix.neg  <= mono_c[achr_pkg::SAMPLE_W-1];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/achr_ctrl.sv =====
// Mode controller: idle/attack/hold/release sequencing, countdown and gain.
// Depends on achr_pkg and the assertion macro header.
`default_nettype none
`include "audio_compressor_attack_hold_release_unit_defines.svh"

module achr_ctrl #(
  parameter int COUNT_BITS = 20
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          upd,
  input  wire logic [achr_pkg::SAMPLE_W-1:0] mag,
  input  wire achr_pkg::cfg_t                cfg,
  output achr_pkg::gain_t                    gain_next,
  output achr_pkg::mode_t                    mode_next
);

  localparam int SUM_W = achr_pkg::GAIN_W + 1;

  achr_pkg::mode_t        mode;
  logic [COUNT_BITS-1:0]  countdown;
  achr_pkg::gain_t        gain_value;

  achr_pkg::mode_t        mode_pre;
  logic [COUNT_BITS-1:0]  count_pre;
  logic [COUNT_BITS-1:0]  countdown_next;

  logic                   above;
  logic                   below;
  achr_pkg::gain_t        floor_g;
  achr_pkg::gain_t        astep_g;
  achr_pkg::gain_t        gain_dec;
  logic [SUM_W-1:0]       gain_sum;
  achr_pkg::gain_t        gain_inc;
  logic [COUNT_BITS-1:0]  att_len;
  logic [COUNT_BITS-1:0]  rel_len;
  logic [COUNT_BITS-1:0]  hold_len;
  logic                   att_go;
  logic                   rel_go;

  assign above    = mag > cfg.level_threshold;
  assign below    = mag < cfg.level_threshold;
  assign floor_g  = achr_pkg::gain_t'(cfg.gain_floor);
  assign astep_g  = achr_pkg::gain_t'(cfg.attack_gain_step);
  assign att_len  = COUNT_BITS'(cfg.attack_length);
  assign rel_len  = COUNT_BITS'(cfg.release_length);
  assign hold_len = COUNT_BITS'(cfg.hold_length);

  // saturating step arithmetic
  assign gain_dec = (gain_value > astep_g) ? (gain_value - astep_g) : '0;
  assign gain_sum = {1'b0, gain_value} + SUM_W'(cfg.release_gain_step);
  assign gain_inc = gain_sum[SUM_W-1] ? achr_pkg::GAIN_MAX
                                      : gain_sum[achr_pkg::GAIN_W-1:0];

  assign att_go = (count_pre != '0) && (gain_value > floor_g);
  assign rel_go = (count_pre != '0) && (gain_value < achr_pkg::GAIN_ONE);

  // level-driven transitions, applied before the per-mode step
  always_comb begin
    mode_pre  = mode;
    count_pre = countdown;
    if (above) begin
      if ((gain_value >= floor_g) &&
          (mode inside {achr_pkg::MODE_IDLE, achr_pkg::MODE_RELEASE})) begin
        mode_pre  = achr_pkg::MODE_ATTACK;
        count_pre = att_len;
      end
      if (mode_pre == achr_pkg::MODE_HOLD) begin
        count_pre = hold_len;
      end
    end
    if (below && (gain_value <= achr_pkg::GAIN_ONE) && (count_pre == '0) &&
        (mode_pre == achr_pkg::MODE_HOLD)) begin
      mode_pre  = achr_pkg::MODE_RELEASE;
      count_pre = rel_len;
    end
  end

  // next mode
  always_comb begin
    case (mode_pre)
      achr_pkg::MODE_ATTACK:  mode_next = att_go ? achr_pkg::MODE_ATTACK
                                                 : achr_pkg::MODE_HOLD;
      achr_pkg::MODE_HOLD:    mode_next = (count_pre != '0) ? achr_pkg::MODE_HOLD
                                                            : achr_pkg::MODE_RELEASE;
      achr_pkg::MODE_RELEASE: mode_next = rel_go ? achr_pkg::MODE_RELEASE
                                                 : achr_pkg::MODE_IDLE;
      default:                mode_next = achr_pkg::MODE_IDLE;
    endcase
  end

  // countdown and gain per mode
  always_comb begin
    countdown_next = count_pre;
    gain_next      = gain_value;
    case (mode_pre)
      achr_pkg::MODE_ATTACK: begin
        if (att_go) begin
          gain_next      = gain_dec;
          countdown_next = count_pre - COUNT_BITS'(1);
        end else begin
          countdown_next = hold_len;
        end
      end
      achr_pkg::MODE_HOLD: begin
        if (count_pre != '0) begin
          countdown_next = count_pre - COUNT_BITS'(1);
        end else begin
          countdown_next = rel_len;
        end
      end
      achr_pkg::MODE_RELEASE: begin
        if (rel_go) begin
          gain_next      = gain_inc;
          countdown_next = count_pre - COUNT_BITS'(1);
        end
      end
      default: begin
        if (gain_value < achr_pkg::GAIN_ONE) begin
          gain_next = achr_pkg::GAIN_ONE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= achr_pkg::MODE_IDLE;
      countdown  <= '0;
      gain_value <= achr_pkg::GAIN_ONE;
    end else if (upd) begin
      mode       <= mode_next;
      countdown  <= countdown_next;
      gain_value <= gain_next;
    end
  end

  `ACHR_ASSERT_NEXT(a_hold_keeps_gain, clk, rst, upd && mode_next == achr_pkg::MODE_HOLD, gain_value == $past(gain_value), "gain changed on a step that ends in hold")
  `ACHR_ASSERT_NEXT(a_attack_no_raise, clk, rst, upd && mode_next == achr_pkg::MODE_ATTACK, gain_value <= $past(gain_value), "gain rose during attack")
  `ACHR_ASSERT_NEXT(a_idle_gain, clk, rst, upd && mode_next == achr_pkg::MODE_IDLE, gain_value == $past(gain_value) || gain_value == achr_pkg::GAIN_ONE, "idle step moved gain to a value other than unity")

endmodule

`default_nettype wire

// ===== hdl/achr_apply.sv =====
// Gain multiply (registered product) and output saturation (result register).
// Depends on achr_pkg.
`default_nettype none

module achr_apply (
  input  wire logic                 clk,
  input  wire logic                 en_prod,
  input  wire logic                 en_out,
  input  wire achr_pkg::apply_in_t  src,
  output achr_pkg::out_item_t       item
);

  localparam int PROD_W = achr_pkg::SAMPLE_W + achr_pkg::GAIN_W;
  localparam int PM_W   = PROD_W - achr_pkg::GAIN_FRAC_BITS;

  logic [PROD_W-1:0]                     prod;
  logic                                  neg_q;
  logic signed [achr_pkg::SAMPLE_W-1:0]  mono_q;
  achr_pkg::gain_t                       gain_q;
  achr_pkg::mode_t                       mode_q;

  logic [PM_W-1:0]                       pm;
  logic                                  ovf;
  logic [achr_pkg::SAMPLE_W-1:0]         res;

  always_ff @(posedge clk) begin
    if (en_prod) begin
      prod   <= PROD_W'(src.mag) * PROD_W'(src.gain);
      neg_q  <= src.neg;
      mono_q <= src.mono;
      gain_q <= src.gain;
      mode_q <= src.mode;
    end
  end

  // truncation toward zero: scale the magnitude, then reapply the sign
  assign pm  = prod[PROD_W-1:achr_pkg::GAIN_FRAC_BITS];
  assign ovf = |pm[PM_W-1:achr_pkg::SAMPLE_W-1];

  always_comb begin
    if (neg_q) begin
      res = ovf ? achr_pkg::SAT_NEG
                : (achr_pkg::SAMPLE_W'(0) - pm[achr_pkg::SAMPLE_W-1:0]);
    end else begin
      res = ovf ? achr_pkg::SAT_POS : pm[achr_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      item.compressed_sample <= $signed(res);
      item.mono_passthrough  <= mono_q;
      item.current_gain      <= gain_q;
      item.current_mode      <= mode_q;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/audio_compressor_attack_hold_release_unit.sv =====
// Throughput: one item per cycle while out_stall is low; back-pressure stalls the input.
// The mode/countdown/gain loop closes in a single stage.
// Pipeline: input register, mono mix, controller, gain product, saturated result register.
// Reset (rst, synchronous): config registers to defaults, mode idle, countdown 0,
// gain 1.0, all stage valids cleared.
// Depends on achr_pkg, achr_mix, achr_ctrl, achr_apply and the assertion macro header.
`default_nettype none
`include "audio_compressor_attack_hold_release_unit_defines.svh"

module audio_compressor_attack_hold_release_unit #(
  parameter int COUNT_BITS = 20
) (
  input  wire logic                             clk,
  input  wire logic                             rst,

  // configuration write port
  input  wire logic                             cfg_wr_en,
  input  wire logic [achr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [achr_pkg::CFG_DATA_W-1:0]  cfg_data,

  // stereo frame in
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire achr_pkg::in_item_t               in_data,

  // compressed result out
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output achr_pkg::out_item_t                   out_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Unknown indexes are dropped.
  // ---------------------------------------------------------------------------
  achr_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= achr_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      case (achr_pkg::cfg_reg_t'(cfg_index))
        achr_pkg::REG_LEVEL_THRESHOLD:   cfg.level_threshold   <= cfg_data;
        achr_pkg::REG_GAIN_FLOOR:        cfg.gain_floor        <= cfg_data[achr_pkg::STEP_W-1:0];
        achr_pkg::REG_ATTACK_GAIN_STEP:  cfg.attack_gain_step  <= cfg_data[achr_pkg::STEP_W-1:0];
        achr_pkg::REG_RELEASE_GAIN_STEP: cfg.release_gain_step <= cfg_data[achr_pkg::STEP_W-1:0];
        achr_pkg::REG_ATTACK_LENGTH:     cfg.attack_length     <= cfg_data[achr_pkg::LEN_W-1:0];
        achr_pkg::REG_RELEASE_LENGTH:    cfg.release_length    <= cfg_data[achr_pkg::LEN_W-1:0];
        achr_pkg::REG_HOLD_LENGTH:       cfg.hold_length       <= cfg_data[achr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage valids and back-pressure. Each stage loads when it is empty or the
  // next one moves, so bubbles close up and a waiting result does not block
  // the input until every stage is occupied.
  // ---------------------------------------------------------------------------
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready;

  assign s5_ready = !out_valid || !out_stall;
  assign s4_ready = !s4_valid  || s5_ready;
  assign s3_ready = !s3_valid  || s4_ready;
  assign s2_ready = !s2_valid  || s3_ready;
  assign s1_ready = !s1_valid  || s2_ready;
  assign in_stall = !s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid  <= in_valid;
      if (s2_ready) s2_valid  <= s1_valid;
      if (s3_ready) s3_valid  <= s2_valid;
      if (s4_ready) s4_valid  <= s3_valid;
      if (s5_ready) out_valid <= s4_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------------
  achr_pkg::in_item_t in_q;

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      in_q <= in_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: mono mix, magnitude and sign
  // ---------------------------------------------------------------------------
  achr_pkg::mix_t mix_q;

  achr_mix u_mix (
    .clk  (clk),
    .en   (s2_ready && s1_valid),
    .item (in_q),
    .mix  (mix_q)
  );

  // ---------------------------------------------------------------------------
  // Stage 3: controller. Its state advances exactly once per item, when the
  // item leaves stage 2; the updated gain and mode ride along with the item.
  // ---------------------------------------------------------------------------
  logic              ctrl_upd;
  achr_pkg::gain_t   gain_next;
  achr_pkg::mode_t   mode_next;
  achr_pkg::apply_in_t s3_q;

  assign ctrl_upd = s3_ready && s2_valid;

  achr_ctrl #(
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .upd       (ctrl_upd),
    .mag       (mix_q.mag),
    .cfg       (cfg),
    .gain_next (gain_next),
    .mode_next (mode_next)
  );

  always_ff @(posedge clk) begin
    if (ctrl_upd) begin
      s3_q.mono <= mix_q.mono;
      s3_q.mag  <= mix_q.mag;
      s3_q.neg  <= mix_q.neg;
      s3_q.gain <= gain_next;
      s3_q.mode <= mode_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 4 and 5: 32x26 product, then saturation into the result register
  // ---------------------------------------------------------------------------
  achr_apply u_apply (
    .clk     (clk),
    .en_prod (s4_ready && s3_valid),
    .en_out  (s5_ready && s4_valid),
    .src     (s3_q),
    .item    (out_data)
  );

  `ACHR_ASSERT_NOW(a_empty_out_no_stall, clk, rst, !out_valid, !in_stall, "input stalled with an empty result register")
  `ACHR_ASSERT_NOW(a_out_from_pipe, clk, rst, $rose(out_valid), $past(s4_valid), "result appeared without an item in the product stage")
  `ACHR_ASSERT_NOW(a_full_pipe_stalls, clk, rst, s1_valid && s2_valid && s3_valid && s4_valid && out_valid && out_stall, in_stall, "input taken while every stage is held")

endmodule

`default_nettype wire
